@@ rtl/spr_pkg.sv @@
// Shared types and constants of the Simpson panel refiner.
// No dependencies; used by every other file of the block except spr_if.
package spr_pkg;

  localparam int DataW = 32;
  localparam int ErrW  = 31;
  localparam int IdxW  = 13;
  localparam int CntW  = 12;

  localparam int MaxPoints = 4096;

  localparam logic [ErrW-1:0] TolReset = ErrW'(66);
  localparam logic [ErrW-1:0] ErrSat   = {ErrW{1'b1}};

  localparam int QueueDepth = 2;

  typedef enum logic {
    JOB_FLUSH,
    JOB_PANEL
  } job_kind_e;

  typedef struct packed {
    logic signed [DataW-1:0] sample_energy;
    logic signed [DataW-1:0] sample_cond;
    logic                    is_last;
  } sample_t;

  // one unit of work for the back end: buffered points plus the closing sample
  typedef struct packed {
    job_kind_e              kind;
    logic [2:0]             n_old;
    logic                   status;
    logic                   last;
    logic [3:0][DataW-1:0]  win_e;
    logic [3:0][DataW-1:0]  win_c;
    logic [DataW-1:0]       sample_energy;
    logic [DataW-1:0]       sample_cond;
  } job_t;

  typedef struct packed {
    job_t                   job;
    logic [ErrW-1:0]        tol;
    logic [3:0][DataW-1:0]  mid;
  } eval_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_energy;
    logic signed [DataW-1:0] out_cond;
    logic                    is_inserted;
    logic [IdxW-1:0]         new_index;
    logic                    last_result;
    logic [ErrW-1:0]         max_error;
    logic [CntW-1:0]         inserted_count;
    logic                    status;
  } result_t;

endpackage

@@ rtl/spr_if.sv @@
// Channel interfaces of the Simpson panel refiner: samples, results, config.
// Depends on nothing.
interface spr_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_energy;
  logic signed [31:0] sample_cond;
  logic               is_last;

  modport source (output valid, sample_energy, sample_cond, is_last, input ready);
  modport sink   (input valid, sample_energy, sample_cond, is_last, output ready);
endinterface

interface spr_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_energy;
  logic signed [31:0] out_cond;
  logic               is_inserted;
  logic [12:0]        new_index;
  logic               last_result;
  logic [30:0]        max_error;
  logic [11:0]        inserted_count;
  logic               status;

  modport source (output valid, out_energy, out_cond, is_inserted, new_index, last_result,
                  max_error, inserted_count, status, input ready);
  modport sink   (input valid, out_energy, out_cond, is_inserted, new_index, last_result,
                  max_error, inserted_count, status, output ready);
endinterface

interface spr_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] error_tolerance;

  modport source (output valid, error_tolerance, input ready);
  modport sink   (input valid, error_tolerance, output ready);
endinterface

@@ rtl/spr_front.sv @@
// Front end: buffers samples into five-point panels and issues jobs.
// Depends on spr_pkg.
module spr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  spr_pkg::sample_t in_data_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output spr_pkg::job_t    job_o
);

  localparam logic [1:0] PhaseFull = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic       first_q, first_d;
  logic [3:0][spr_pkg::DataW-1:0] win_e_q, win_e_d, win_c_q, win_c_d;
  logic       accept;
  logic [1:0] wr_idx;

  assign in_ready_o = job_ready_i;

  always_comb begin
    accept   = in_valid_i && job_ready_i;
    wr_idx   = phase_q + 2'd1;
    phase_d  = phase_q;
    first_d  = first_q;
    win_e_d  = win_e_q;
    win_c_d  = win_c_q;
    job_valid_o         = 1'b0;
    job_o.kind          = spr_pkg::JOB_FLUSH;
    job_o.n_old         = 3'd0;
    job_o.status        = 1'b0;
    job_o.last          = in_data_i.is_last;
    job_o.win_e         = win_e_q;
    job_o.win_c         = win_c_q;
    job_o.sample_energy = in_data_i.sample_energy;
    job_o.sample_cond   = in_data_i.sample_cond;
    if (accept) begin
      if (!first_q) begin
        if (in_data_i.is_last) begin
          job_valid_o = 1'b1;
        end else begin
          win_e_d[0] = in_data_i.sample_energy;
          win_c_d[0] = in_data_i.sample_cond;
          phase_d    = 2'd0;
          first_d    = 1'b1;
        end
      end else if (phase_q != PhaseFull) begin
        if (in_data_i.is_last) begin
          // short stream tail: flush what is buffered
          job_valid_o  = 1'b1;
          job_o.n_old  = {1'b0, phase_q} + 3'd1;
          job_o.status = 1'b1;
          first_d      = 1'b0;
          phase_d      = 2'd0;
        end else begin
          win_e_d[wr_idx] = in_data_i.sample_energy;
          win_c_d[wr_idx] = in_data_i.sample_cond;
          phase_d         = wr_idx;
        end
      end else begin
        job_valid_o = 1'b1;
        job_o.kind  = spr_pkg::JOB_PANEL;
        job_o.n_old = 3'd4;
        phase_d     = 2'd0;
        if (in_data_i.is_last) begin
          first_d = 1'b0;
        end else begin
          win_e_d[0] = in_data_i.sample_energy;
          win_c_d[0] = in_data_i.sample_cond;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      first_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_e_q <= win_e_d;
    win_c_q <= win_c_d;
  end

endmodule

@@ rtl/spr_queue.sv @@
// Short job queue between front end and error pipeline.
// Depends on spr_pkg.
module spr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  spr_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output spr_pkg::job_t pop_data_o
);

  localparam int PtrW = (spr_pkg::QueueDepth > 1) ? $clog2(spr_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(spr_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(spr_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(spr_pkg::QueueDepth);

  spr_pkg::job_t   mem_q [spr_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/spr_err.sv @@
// Panel error pipeline: five stages forming |de|*|S|/(3*65536), saturated,
// plus the four midpoints. Depends on spr_pkg.
module spr_err (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spr_pkg::job_t  job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spr_pkg::eval_t out_o
);

  localparam logic [52:0] SatLimit = 53'd6442450944;  // 3 * 2^31
  localparam logic [31:0] RecipThird = 32'h5555_5555;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en;

  spr_pkg::job_t j1_q, j2_q, j3_q, j4_q, j5_q;

  // stage 1
  logic signed [32:0] de;
  logic signed [37:0] c0x, c1x, c2x, c3x, c4x, s_sum, b_full;
  logic signed [32:0] a_full, half_full;
  logic [32:0] a1_q;
  logic [35:0] b1_q;
  logic [31:0] half1_q;

  // stage 2
  logic [50:0] pl_d, ph_d, pl2_q, ph2_q;
  logic [3:0][31:0] mid_d, mid2_q, mid3_q, mid4_q, mid5_q;
  logic signed [32:0] msum [4];

  // stage 3
  logic [68:0] prod;
  logic [52:0] t_full;
  logic        sat3_q, sat4_q;
  logic [32:0] tl3_q, tl4_q;

  // stage 4
  logic [64:0] m_full;
  logic [32:0] q0_4_q;

  // stage 5
  logic [34:0] three_q0, rem;
  logic [32:0] q_fix;
  logic [spr_pkg::ErrW-1:0] tol5_q;

  assign en          = !v5_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v5_q;
  assign out_o.job   = j5_q;
  assign out_o.tol   = tol5_q;
  assign out_o.mid   = mid5_q;

  always_comb begin
    de  = $signed({job_i.win_e[1][31], job_i.win_e[1]})
        - $signed({job_i.win_e[0][31], job_i.win_e[0]});
    c0x = $signed({{6{job_i.win_c[0][31]}}, job_i.win_c[0]});
    c1x = $signed({{6{job_i.win_c[1][31]}}, job_i.win_c[1]});
    c2x = $signed({{6{job_i.win_c[2][31]}}, job_i.win_c[2]});
    c3x = $signed({{6{job_i.win_c[3][31]}}, job_i.win_c[3]});
    c4x = $signed({{6{job_i.sample_cond[31]}}, job_i.sample_cond});
    s_sum = c0x - (c1x <<< 2) + (c2x <<< 2) + (c2x <<< 1) - (c3x <<< 2) + c4x;
    b_full    = s_sum[37] ? -s_sum : s_sum;
    a_full    = de[32] ? -de : de;
    half_full = de >>> 1;
  end

  always_comb begin
    pl_d = a1_q * b1_q[17:0];
    ph_d = a1_q * b1_q[35:18];
    for (int k = 0; k < 4; k++) begin
      msum[k] = $signed({j1_q.win_e[k][31], j1_q.win_e[k]})
              + $signed({half1_q[31], half1_q});
      if (msum[k][32] != msum[k][31]) begin
        mid_d[k] = msum[k][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        mid_d[k] = msum[k][31:0];
      end
    end
  end

  assign prod   = {18'd0, pl2_q} + {ph2_q, 18'd0};
  assign t_full = prod[68:16];
  assign m_full = tl3_q * RecipThird;

  always_comb begin
    three_q0 = {2'b00, q0_4_q} + {1'b0, q0_4_q, 1'b0};
    rem      = {2'b00, tl4_q} - three_q0;
    q_fix    = q0_4_q + ((rem >= 35'd3) ? 33'd1 : 33'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j1_q    <= job_i;
      a1_q    <= a_full;
      b1_q    <= b_full[35:0];
      half1_q <= half_full[31:0];

      j2_q    <= j1_q;
      pl2_q   <= pl_d;
      ph2_q   <= ph_d;
      mid2_q  <= mid_d;

      j3_q    <= j2_q;
      mid3_q  <= mid2_q;
      sat3_q  <= (t_full >= SatLimit);
      tl3_q   <= t_full[32:0];

      j4_q    <= j3_q;
      mid4_q  <= mid3_q;
      sat4_q  <= sat3_q;
      tl4_q   <= tl3_q;
      q0_4_q  <= m_full[64:32];

      j5_q    <= j4_q;
      mid5_q  <= mid4_q;
      tol5_q  <= sat4_q ? spr_pkg::ErrSat : q_fix[spr_pkg::ErrW-1:0];
    end
  end

endmodule

@@ rtl/spr_back.sv @@
// Back end: refine decision, running totals and result sequencing into the
// output register; holds the tolerance register. Depends on spr_pkg.
module spr_back #(
  parameter int MaxPoints = spr_pkg::MaxPoints
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [spr_pkg::ErrW-1:0]  cfg_data_i,
  input  logic                      eval_valid_i,
  output logic                      eval_ready_o,
  input  spr_pkg::eval_t            eval_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output spr_pkg::result_t          out_o
);

  localparam int CntMax    = (1 << spr_pkg::CntW) - 1;
  localparam int InsertCap = (MaxPoints - 1 < CntMax) ? MaxPoints - 1 : CntMax;
  localparam logic [spr_pkg::CntW:0] CapW = (spr_pkg::CntW + 1)'(InsertCap);

  logic [spr_pkg::ErrW-1:0] tol_q;
  spr_pkg::eval_t           cur_q;
  logic                     cur_valid_q, cur_valid_d;
  logic                     refine_q, refine_d;
  logic [3:0]               step_q, step_d;
  logic [spr_pkg::IdxW-1:0] pos_q, pos_d;
  logic [spr_pkg::CntW-1:0] ins_q, ins_d, ins_base;
  logic [spr_pkg::ErrW-1:0] lrg_q, lrg_d, lrg_base;
  spr_pkg::result_t         out_q, res;
  logic                     out_valid_q;

  logic       out_free, emit, finish, restart, load, in_body, is_ins;
  logic [3:0] body, total;
  logic [1:0] idx;

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;
  assign eval_ready_o = !cur_valid_q || finish;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    emit     = cur_valid_q && out_free;
    body     = refine_q ? 4'd8 : {1'b0, cur_q.job.n_old};
    total    = body + {3'b000, cur_q.job.last};
    finish   = emit && (step_q == total - 4'd1);
    restart  = finish && cur_q.job.last;
    load     = eval_valid_i && (!cur_valid_q || finish);

    in_body = (step_q < body);
    idx     = refine_q ? step_q[2:1] : step_q[1:0];
    is_ins  = refine_q && step_q[0] && in_body;

    res.is_inserted    = is_ins;
    res.new_index      = pos_q;
    res.last_result    = !in_body;
    res.max_error      = lrg_q;
    res.inserted_count = ins_q;
    res.status         = cur_q.job.status;
    if (!in_body) begin
      res.out_energy = cur_q.job.sample_energy;
      res.out_cond   = cur_q.job.sample_cond;
    end else if (is_ins) begin
      res.out_energy = cur_q.mid[idx];
      res.out_cond   = '0;
    end else begin
      res.out_energy = cur_q.job.win_e[idx];
      res.out_cond   = cur_q.job.win_c[idx];
    end

    lrg_base = restart ? '0 : lrg_q;
    ins_base = restart ? '0 : ins_q;
    pos_d    = restart ? '0 : (emit ? pos_q + spr_pkg::IdxW'(1) : pos_q);
    lrg_d    = lrg_base;
    ins_d    = ins_base;
    refine_d = refine_q;
    if (load) begin
      refine_d = 1'b0;
      if (eval_i.job.kind == spr_pkg::JOB_PANEL) begin
        if (eval_i.tol > lrg_base) begin
          lrg_d = eval_i.tol;
        end
        if ((eval_i.tol > tol_q) && (({1'b0, ins_base} + 13'd4) <= CapW)) begin
          refine_d = 1'b1;
          ins_d    = ins_base + spr_pkg::CntW'(4);
        end
      end
    end

    cur_valid_d = load ? 1'b1 : (finish ? 1'b0 : cur_valid_q);
    step_d      = load ? 4'd0 : (emit ? step_q + 4'd1 : step_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= spr_pkg::TolReset;
      cur_valid_q <= 1'b0;
      refine_q    <= 1'b0;
      step_q      <= 4'd0;
      pos_q       <= '0;
      ins_q       <= '0;
      lrg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
      cur_valid_q <= cur_valid_d;
      refine_q    <= refine_d;
      step_q      <= step_d;
      pos_q       <= pos_d;
      ins_q       <= ins_d;
      lrg_q       <= lrg_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= eval_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

endmodule

@@ rtl/simpson_panel_refiner.sv @@
// Simpson panel refiner top level: front end, job queue, error pipeline, back end.
// Depends on spr_pkg, spr_if, spr_front, spr_queue, spr_err, spr_back.
// Throughput: one sample per cycle in while the job queue has room; one result per cycle out from the output
//   register while not stalled: 4 results per kept panel, 8 per refined one (plus 1 for the last sample).
// Reset: async active low; clears all stream state, tolerance returns to 66, no sweep.
module simpson_panel_refiner #(
  parameter int MaxPoints = spr_pkg::MaxPoints
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spr_sample_if.sink   in_i,
  spr_result_if.source out_o,
  spr_cfg_if.sink      cfg_i
);

  spr_pkg::sample_t smp;
  spr_pkg::job_t    fq_job, qe_job;
  spr_pkg::eval_t   eb_eval;
  spr_pkg::result_t res;
  logic fq_valid, fq_ready, qe_valid, qe_ready, eb_valid, eb_ready;

  assign smp.sample_energy = in_i.sample_energy;
  assign smp.sample_cond   = in_i.sample_cond;
  assign smp.is_last       = in_i.is_last;

  spr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (smp),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  spr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_job),
    .pop_valid_o  (qe_valid),
    .pop_ready_i  (qe_ready),
    .pop_data_o   (qe_job)
  );

  spr_err u_err (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qe_valid),
    .in_ready_o  (qe_ready),
    .job_i       (qe_job),
    .out_valid_o (eb_valid),
    .out_ready_i (eb_ready),
    .out_o       (eb_eval)
  );

  spr_back #(
    .MaxPoints (MaxPoints)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_ready_o  (cfg_i.ready),
    .cfg_data_i   (cfg_i.error_tolerance),
    .eval_valid_i (eb_valid),
    .eval_ready_o (eb_ready),
    .eval_i       (eb_eval),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_o        (res)
  );

  assign out_o.out_energy     = res.out_energy;
  assign out_o.out_cond       = res.out_cond;
  assign out_o.is_inserted    = res.is_inserted;
  assign out_o.new_index      = res.new_index;
  assign out_o.last_result    = res.last_result;
  assign out_o.max_error      = res.max_error;
  assign out_o.inserted_count = res.inserted_count;
  assign out_o.status         = res.status;

endmodule

@@ bench/tb_simpson_panel_refiner.sv @@
`timescale 1ns / 1ps
// Self-checking bench for simpson_panel_refiner: directed and random sample streams,
// a cycle-free predictor of the refined point sequence, field-by-field result checks.
// Depends on spr_pkg, the spr_*_if interfaces and the simpson_panel_refiner RTL.
module tb_simpson_panel_refiner;

  localparam int ClkPeriod = 12;
  localparam int TimeoutCycles = 1_000_000;
  localparam int SettleCycles = 32;
  localparam int MaxInserted = 4095;
  localparam logic [30:0] ErrorCeiling = 31'h7FFF_FFFF;
  localparam longint PosLimit = 64'sd2147483647;
  localparam longint NegLimit = -64'sd2147483648;

  logic clk;
  logic rst_n;

  spr_sample_if in_if ();
  spr_result_if out_if ();
  spr_cfg_if cfg_if ();

  simpson_panel_refiner DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  spr_pkg::sample_t pending_samples[$];
  spr_pkg::result_t expected_points[$];
  int unsigned samples_queued;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // predictor state
  logic [30:0] tol_setting = spr_pkg::TolReset;
  logic [31:0] win_e[4];
  logic [31:0] win_c[4];
  int unsigned phase_cnt = 0;
  bit have_start = 1'b0;
  logic [12:0] out_pos = '0;
  int unsigned ins_total = 0;
  logic [30:0] err_peak = '0;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  task automatic emit(logic [31:0] e, logic [31:0] c, bit ins, bit last, bit st);
    spr_pkg::result_t r;
    r.out_energy = e;
    r.out_cond = c;
    r.is_inserted = ins;
    r.new_index = out_pos;
    r.last_result = last;
    r.max_error = err_peak;
    r.inserted_count = ins_total[11:0];
    r.status = st;
    expected_points.push_back(r);
    out_pos = out_pos + 13'd1;
  endtask

  task automatic restart_stream();
    phase_cnt = 0;
    have_start = 1'b0;
    out_pos = '0;
    ins_total = 0;
    err_peak = '0;
  endtask

  // |de|/3 * |c0 - 4c1 + 6c2 - 4c3 + c4| in Q16.16, saturated
  function automatic logic [30:0] panel_error(logic [31:0] c4);
    longint de, s;
    logic [63:0] a, b;
    logic [127:0] q;
    de = longint'($signed(win_e[1])) - longint'($signed(win_e[0]));
    s = longint'($signed(win_c[0])) - 4 * longint'($signed(win_c[1]))
      + 6 * longint'($signed(win_c[2])) - 4 * longint'($signed(win_c[3]))
      + longint'($signed(c4));
    a = (de < 0) ? -de : de;
    b = (s < 0) ? -s : s;
    q = (128'(a) * 128'(b)) / 128'd196608;
    return (q > 128'(ErrorCeiling)) ? ErrorCeiling : q[30:0];
  endfunction

  task automatic refine_sample(logic [31:0] e, logic [31:0] c, bit last);
    logic [30:0] err;
    longint de, half, mid;
    if (!have_start) begin
      if (last) begin
        emit(e, c, 1'b0, 1'b1, 1'b0);
        restart_stream();
      end else begin
        win_e[0] = e;
        win_c[0] = c;
        phase_cnt = 0;
        have_start = 1'b1;
      end
    end else if (phase_cnt < 3) begin
      if (last) begin
        // short stream: flush buffered points unchanged, flagged bad count
        for (int k = 0; k <= phase_cnt; k++) emit(win_e[k], win_c[k], 1'b0, 1'b0, 1'b1);
        emit(e, c, 1'b0, 1'b1, 1'b1);
        restart_stream();
      end else begin
        phase_cnt++;
        win_e[phase_cnt] = e;
        win_c[phase_cnt] = c;
      end
    end else begin
      err = panel_error(c);
      if (err > err_peak) err_peak = err;
      if (err > tol_setting && ins_total + 4 <= MaxInserted) begin
        de = longint'($signed(win_e[1])) - longint'($signed(win_e[0]));
        half = de >>> 1;
        ins_total += 4;
        for (int k = 0; k < 4; k++) begin
          emit(win_e[k], win_c[k], 1'b0, 1'b0, 1'b0);
          mid = longint'($signed(win_e[k])) + half;
          if (mid > PosLimit) mid = PosLimit;
          if (mid < NegLimit) mid = NegLimit;
          emit(mid[31:0], '0, 1'b1, 1'b0, 1'b0);
        end
      end else begin
        for (int k = 0; k < 4; k++) emit(win_e[k], win_c[k], 1'b0, 1'b0, 1'b0);
      end
      if (last) begin
        emit(e, c, 1'b0, 1'b1, 1'b0);
        restart_stream();
      end else begin
        win_e[0] = e;
        win_c[0] = c;
        phase_cnt = 0;
      end
    end
  endtask

  always @(posedge clk) begin : sample_driver
    spr_pkg::sample_t nxt;
    bit take;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      take = !in_if.valid;
      if (in_if.valid && in_if.ready) begin
        refine_sample(in_if.sample_energy, in_if.sample_cond, in_if.is_last);
        take = 1'b1;
      end
      if (take) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          in_if.valid <= 1'b1;
          in_if.sample_energy <= nxt.sample_energy;
          in_if.sample_cond <= nxt.sample_cond;
          in_if.is_last <= nxt.is_last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    spr_pkg::result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual index %h energy %h",
                   $time, out_if.new_index, out_if.out_energy);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("out_energy", want.out_energy, out_if.out_energy);
          check_field("out_cond", want.out_cond, out_if.out_cond);
          check_field("is_inserted", want.is_inserted, out_if.is_inserted);
          check_field("new_index", want.new_index, out_if.new_index);
          check_field("last_result", want.last_result, out_if.last_result);
          check_field("max_error", want.max_error, out_if.max_error);
          check_field("inserted_count", want.inserted_count, out_if.inserted_count);
          check_field("status", want.status, out_if.status);
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_sample(logic [31:0] e, logic [31:0] c, bit last);
    spr_pkg::sample_t s;
    s.sample_energy = e;
    s.sample_cond = c;
    s.is_last = last;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // one stream: mostly uniform spacing, integrand per panel smooth, noisy or wild
  task automatic queue_stream(int unsigned len);
    logic [31:0] e0, de, base, slope, amp, e, c;
    int unsigned spacing, shape;
    spacing = $urandom_range(0, 9);
    e0 = $urandom;
    shape = 0;
    base = '0;
    slope = '0;
    amp = '0;
    if (spacing < 5) de = $urandom_range(1, 32'h0004_0000);
    else if (spacing == 5) de = -$urandom_range(1, 32'h0004_0000);
    else if (spacing == 6) de = '0;
    else de = $urandom;
    for (int k = 0; k < len; k++) begin
      if (k % 4 == 0) begin
        shape = $urandom_range(0, 3);
        base = $urandom;
        slope = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        amp = 32'd1 << $urandom_range(2, 14);
      end
      e = (spacing >= 8) ? $urandom : e0 + de * k;
      case (shape)
        0: c = base + slope * k;
        1, 2: c = base + $urandom_range(0, 2 * amp) - amp;
        default: c = $urandom;
      endcase
      push_sample(e, c, k == len - 1);
    end
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned r, len;
    samples_queued = 0;
    while (samples_queued < count) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        len = 4 * $urandom_range(1, 5) + 1;
      end else if (r == 7) begin
        len = 1;
      end else begin
        len = $urandom_range(2, 14);
        if (len % 4 == 1) len++;
      end
      queue_stream(len);
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_if.valid || expected_points.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [30:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.error_tolerance <= v;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tol_setting = v;
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample_energy = '0;
    in_if.sample_cond = '0;
    in_if.is_last = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.error_tolerance = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 76;
    // single-sample stream
    push_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // refined panel, then a linear panel that is kept
    push_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
    push_sample(32'h0002_0000, 32'h0000_0000, 1'b0);
    push_sample(32'h0003_0000, 32'h0001_0000, 1'b0);
    push_sample(32'h0004_0000, 32'h0000_0000, 1'b0);
    push_sample(32'h0005_0000, 32'h0000_1000, 1'b0);
    push_sample(32'h0006_0000, 32'h0000_2000, 1'b0);
    push_sample(32'h0007_0000, 32'h0000_3000, 1'b0);
    push_sample(32'h0008_0000, 32'h0000_4000, 1'b1);
    // saturated error, midpoints clipped high then low
    push_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    push_sample(32'h0000_0005, 32'h8000_0000, 1'b0);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_sample(32'h0000_0001, 32'h8000_0000, 1'b0);
    push_sample(32'h1234_5678, 32'h7FFF_FFFF, 1'b1);
    // bad sample counts
    push_sample(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    push_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    push_sample(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    push_sample(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    push_sample(32'h0001_0000, 32'h8000_0000, 1'b1);
    drain();

    write_tolerance(ErrorCeiling);
    queue_random(90);
    drain();

    send_idle_pct = 76;
    recv_idle_pct = 30;
    write_tolerance('0);
    queue_random(90);
    drain();
    write_tolerance(31'($urandom_range(1, 32'h0004_0000)));
    queue_random(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tolerance(spr_pkg::TolReset);
    queue_random(100);
    drain();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(ClkPeriod * TimeoutCycles);
    $display("TB_ERROR");
    $finish;
  end

endmodule
